// ----- design/pba_pkg.sv -----
// shared types and constants of the page bitmap allocator
// no dependencies; imported by every module of the block
package pba_pkg;

   localparam int NUM_PAGES   = 64;
   localparam int IDX_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int PCNT_W      = $clog2(NUM_PAGES + 1);
   localparam int PID_W       = 16;
   localparam int TIME_W      = 16;
   localparam int NEED_W      = 16;
   localparam int PSIZE_W     = 16;
   localparam int GRANT_W     = 7;
   localparam int FREEB_W     = 22;
   localparam int PROD_W      = (PCNT_W + PSIZE_W > FREEB_W) ? PCNT_W + PSIZE_W : FREEB_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = PSIZE_W'(4096);
   localparam logic [FREEB_W-1:0] FREE_BYTES_MAX  = {FREEB_W{1'b1}};

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_HELD     = 3'd1,
      ST_NO_MEM   = 3'd2,
      ST_RELEASED = 3'd3,
      ST_UNKNOWN  = 3'd4
   } status_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic              kind;
      logic [PID_W-1:0]  pid;
      logic [NEED_W-1:0] need;
   } item_type;

endpackage

// ----- design/pba_front.sv -----
// request intake: takes a request transfer and works out the page count
// depends on pba_pkg
module pba_front import pba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_kind,
   input  logic [PID_W-1:0]  in_pid,
   input  logic [TIME_W-1:0] in_time,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item
);

   logic              vld_ff;
   item_type          item_ff;
   logic [TIME_W:0]   time_plus;
   logic [NEED_W-1:0] need_in;

   // pages needed: half the time, rounded up
   assign time_plus = {1'b0, in_time} + (TIME_W + 1)'(1);
   assign need_in   = NEED_W'(time_plus >> 1);

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff.kind <= in_kind;
         item_ff.pid  <= in_pid;
         item_ff.need <= (in_kind == KIND_ALLOC) ? need_in : '0;
      end
   end

endmodule

// ----- design/pba_queue.sv -----
// short queue between request intake and the page engine
// depends on pba_pkg
module pba_queue import pba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/pba_engine.sv -----
// page engine: owner scan, first-fit claim, release and free-byte report
// depends on pba_pkg; holds the used bits and the owner memory
module pba_engine import pba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [PSIZE_W-1:0] page_size,
   input  logic               in_valid,
   output logic               in_ready,
   input  item_type           in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output status_type         out_status,
   output logic [GRANT_W-1:0] out_granted,
   output logic [FREEB_W-1:0] out_free_bytes
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CLAIM,
      S_MUL,
      S_SAT
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

   state_type          state_ff;
   item_type           item_ff;
   logic [NUM_PAGES-1:0] used_ff;
   logic [PCNT_W-1:0]  free_cnt_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               issue_done_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;
   logic               hit_ff;
   logic [PCNT_W-1:0]  granted_ff;
   status_type         status_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_vld_ff;
   status_type         rsp_status_ff;
   logic [GRANT_W-1:0] rsp_granted_ff;
   logic [FREEB_W-1:0] rsp_free_ff;

   logic [PID_W-1:0]   owner_mem [NUM_PAGES];
   logic [PID_W-1:0]   owner_rd_ff;

   logic match;
   logic hit_now;
   logic claim_wr;
   logic rsp_free;
   logic rsp_load;

   assign match    = cmp_vld_ff && used_ff[cmp_idx_ff] && (owner_rd_ff == item_ff.pid);
   assign hit_now  = hit_ff || match;
   assign claim_wr = (state_ff == S_CLAIM) && (NEED_W'(granted_ff) != item_ff.need)
                     && !used_ff[idx_ff];
   assign rsp_free = !rsp_vld_ff || out_ready;
   assign rsp_load = (state_ff == S_SAT) && rsp_free;
   assign in_ready = (state_ff == S_IDLE);

   assign out_valid      = rsp_vld_ff;
   assign out_status     = rsp_status_ff;
   assign out_granted    = rsp_granted_ff;
   assign out_free_bytes = rsp_free_ff;

   // owner memory: one read port for the scan, one write port for the claim
   always_ff @(posedge clock) begin
      if (claim_wr) begin
         owner_mem[idx_ff] <= item_ff.pid;
      end
      owner_rd_ff <= owner_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         free_cnt_ff   <= PCNT_W'(NUM_PAGES);
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         granted_ff    <= '0;
         status_ff     <= ST_GRANTED;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_vld_ff && out_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         cmp_vld_ff <= (state_ff == S_SCAN) && !issue_done_ff;
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  item_ff       <= in_item;
                  idx_ff        <= '0;
                  issue_done_ff <= 1'b0;
                  hit_ff        <= 1'b0;
                  granted_ff    <= '0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               // read issued at idx, compare in the following cycle on the registered owner
               if (!issue_done_ff) begin
                  cmp_idx_ff <= idx_ff;
                  if (idx_ff == LAST_IDX) begin
                     issue_done_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_ff + IDX_W'(1);
                  end
               end
               hit_ff <= hit_now;
               if (match && item_ff.kind == KIND_RELEASE) begin
                  used_ff[cmp_idx_ff] <= 1'b0;
                  free_cnt_ff         <= free_cnt_ff + PCNT_W'(1);
               end
               if (cmp_vld_ff && cmp_idx_ff == LAST_IDX) begin
                  idx_ff <= '0;
                  if (item_ff.kind == KIND_RELEASE) begin
                     status_ff <= hit_now ? ST_RELEASED : ST_UNKNOWN;
                     state_ff  <= S_MUL;
                  end else if (hit_now) begin
                     status_ff <= ST_HELD;
                     state_ff  <= S_MUL;
                  end else if (item_ff.need > NEED_W'(free_cnt_ff)) begin
                     status_ff <= ST_NO_MEM;
                     state_ff  <= S_MUL;
                  end else begin
                     status_ff <= ST_GRANTED;
                     state_ff  <= S_CLAIM;
                  end
               end
            end
            S_CLAIM: begin
               // lowest free pages first; enough are known to be free
               if (NEED_W'(granted_ff) == item_ff.need) begin
                  state_ff <= S_MUL;
               end else begin
                  if (claim_wr) begin
                     used_ff[idx_ff] <= 1'b1;
                     free_cnt_ff     <= free_cnt_ff - PCNT_W'(1);
                     granted_ff      <= granted_ff + PCNT_W'(1);
                  end
                  idx_ff <= (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(free_cnt_ff * page_size);
               state_ff <= S_SAT;
            end
            S_SAT: begin
               if (rsp_free) begin
                  rsp_status_ff  <= status_ff;
                  rsp_granted_ff <= (status_ff == ST_GRANTED) ? GRANT_W'(granted_ff) : '0;
                  rsp_free_ff    <= (prod_ff > PROD_W'(FREE_BYTES_MAX)) ?
                                    FREE_BYTES_MAX : FREEB_W'(prod_ff);
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- design/page_bitmap_allocator.sv -----
// page bitmap allocator: first-fit page pool with per-page owner
// depends on pba_pkg, pba_front, pba_queue and pba_engine
//
// usage
//   request channel (req_): tuser = kind (0 allocate, 1 release),
//   tdata = process id and execution time; an allocate asks for half the
//   time rounded up in pages, all or nothing, lowest free pages first.
//   result channel (rsp_): tuser = status, tdata = pages granted and free
//   bytes (free pages times page size, saturating).
//   csr_wen/csr_wdata write the page size; only while the block is idle.
// operation
//   each request runs an owner scan over the NUM_PAGES entries in the engine,
//   paced by the single read port of the owner memory; a granted allocate
//   adds a claim walk from the lowest page up. Behind intake and queue, the
//   engine then does the free-byte multiply; it takes one request at a
//   time, and the next only once the result register is loaded.
// reset: all pages free, page size 4096, queue and result register empty.
// a stalled receiver holds the result register and the engine holds the next
// result; the queue and intake take up to three further requests before
// req_tready drops.
module page_bitmap_allocator import pba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // process_id[15:0], exec_time[31:16]
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pages_granted[6:0], free_bytes[28:7], zero[31:29]
   output logic [2:0]  rsp_tuser,   // status[2:0]
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   logic [PSIZE_W-1:0] page_size_ff;
   logic               fq_valid;
   logic               fq_ready;
   item_type           fq_item;
   logic               qe_valid;
   logic               qe_ready;
   item_type           qe_item;
   status_type         rsp_status;
   logic [GRANT_W-1:0] rsp_granted;
   logic [FREEB_W-1:0] rsp_free_bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PAGE_SIZE_RESET;
      end else if (csr_wen) begin
         page_size_ff <= csr_wdata;
      end
   end

   pba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_pid    (req_tdata[15:0]),
      .in_time   (req_tdata[31:16]),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   pba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qe_valid),
      .pop_ready  (qe_ready),
      .pop_item   (qe_item)
   );

   pba_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .page_size      (page_size_ff),
      .in_valid       (qe_valid),
      .in_ready       (qe_ready),
      .in_item        (qe_item),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_status     (rsp_status),
      .out_granted    (rsp_granted),
      .out_free_bytes (rsp_free_bytes)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {3'b000, rsp_free_bytes, rsp_granted};

endmodule

// ----- tb/page_bitmap_allocator_tb.sv -----
// self-checking testbench for the page bitmap allocator
// depends on pba_pkg and page_bitmap_allocator; a scoreboard class tracks the page pool
`timescale 1ns / 1ps

module page_bitmap_allocator_tb import pba_pkg::*; ();

   typedef struct {
      status_type          status;
      logic [GRANT_W-1:0]  pages;
      logic [FREEB_W-1:0]  free_bytes;
   } pool_result_type;

   class pool_scoreboard;
      logic                page_used [NUM_PAGES];
      logic [PID_W-1:0]    page_owner [NUM_PAGES];
      logic [PSIZE_W-1:0]  page_size;
      pool_result_type     awaited [$];
      int unsigned         errors;

      function new();
         foreach (page_used[i]) page_used[i] = 1'b0;
         page_size = PAGE_SIZE_RESET;
         errors = 0;
      endfunction

      function int unsigned free_pages();
         int unsigned n;
         n = 0;
         foreach (page_used[i]) if (!page_used[i]) n++;
         return n;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // works out the result of one accepted request and updates the pool
      function void note_request(logic kind, logic [PID_W-1:0] pid,
                                 logic [TIME_W-1:0] exec_time);
         pool_result_type r;
         logic            owned;
         int unsigned     need;
         int unsigned     claimed;
         longint unsigned bytes;
         owned = 1'b0;
         claimed = 0;
         foreach (page_used[i]) if (page_used[i] && page_owner[i] == pid) owned = 1'b1;
         if (kind == KIND_ALLOC) begin
            need = (int'(exec_time) + 1) / 2;
            if (owned) begin
               r.status = ST_HELD;
            end else if (need > free_pages()) begin
               r.status = ST_NO_MEM;
            end else begin
               // first fit, holes allowed
               foreach (page_used[i]) begin
                  if (!page_used[i] && claimed < need) begin
                     page_used[i] = 1'b1;
                     page_owner[i] = pid;
                     claimed++;
                  end
               end
               r.status = ST_GRANTED;
            end
         end else begin
            foreach (page_used[i]) if (page_used[i] && page_owner[i] == pid) page_used[i] = 1'b0;
            r.status = owned ? ST_RELEASED : ST_UNKNOWN;
         end
         r.pages = claimed[GRANT_W-1:0];
         bytes = longint'(free_pages()) * longint'(page_size);
         if (bytes > FREE_BYTES_MAX) bytes = FREE_BYTES_MAX;
         r.free_bytes = bytes[FREEB_W-1:0];
         awaited.insert(awaited.size(), r);
      endfunction

      function void check_result(logic [2:0] status, logic [GRANT_W-1:0] pages,
                                 logic [FREEB_W-1:0] free_bytes);
         pool_result_type r;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result: status %0d pages %0d free_bytes %0d",
                             status, pages, free_bytes));
            return;
         end
         r = awaited.pop_front();
         if (status !== r.status || pages !== r.pages || free_bytes !== r.free_bytes)
            report($sformatf("mismatch: status %0d/%0d pages %0d/%0d free_bytes %0d/%0d (exp/act)",
                             r.status, status, r.pages, pages, r.free_bytes, free_bytes));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // process_id[15:0], exec_time[31:16]
   logic        req_tuser = 1'b0;  // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // pages_granted[6:0], free_bytes[28:7], zero[31:29]
   logic [2:0]  rsp_tuser;         // status[2:0]
   logic        csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;

   bit             no_idle = 1'b0;
   pool_scoreboard sb;
   logic [PID_W-1:0] pid_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                      16'h00FF, 16'h8000, 16'hFFFF, 16'h1234};

   page_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic send_request(logic kind, logic [PID_W-1:0] pid, logic [TIME_W-1:0] exec_time);
      int unsigned gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {exec_time, pid};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, pid, exec_time);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_page_size(logic [PSIZE_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.page_size = value;
   endtask

   task automatic run_random(int unsigned count);
      logic             kind;
      logic [PID_W-1:0] pid;
      logic [TIME_W-1:0] exec_time;
      int unsigned      pick;
      repeat (count) begin
         kind = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_RELEASE;
         pid = ($urandom_range(0, 3) != 0) ? pid_pool[$urandom_range(0, 7)] : PID_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 60)      exec_time = TIME_W'($urandom_range(0, 24));
         else if (pick < 85) exec_time = TIME_W'($urandom_range(0, 130));
         else if (pick < 95) exec_time = TIME_W'($urandom);
         else                exec_time = '0;
         send_request(kind, pid, exec_time);
      end
   endtask

   // result side: random back-pressure, checks each transfer
   initial begin
      int unsigned stall;
      forever begin
         stall = idle_cycles();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (reset || rsp_tvalid !== 1'b1);
         sb.check_result(rsp_tuser, rsp_tdata[6:0], rsp_tdata[28:7]);
      end
   end

   initial begin
      logic [PSIZE_W-1:0] sizes [5];
      sb = new();
      sizes = '{16'hFFFF, 16'h0001, 16'h0000, PSIZE_W'($urandom_range(2, 65534)), PAGE_SIZE_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_page_size(PAGE_SIZE_RESET);

      // zero-page grants leave no ownership behind
      send_request(KIND_ALLOC, 16'h0000, 16'd0);
      send_request(KIND_ALLOC, 16'h0000, 16'd0);
      send_request(KIND_ALLOC, 16'hFFFF, 16'd1);
      send_request(KIND_ALLOC, 16'hFFFF, 16'd5);      // already held
      send_request(KIND_ALLOC, 16'h0001, 16'hFFFF);   // far beyond the pool
      send_request(KIND_ALLOC, 16'h0002, 16'd127);    // one page short
      send_request(KIND_ALLOC, 16'h0002, 16'd126);    // fills the pool
      send_request(KIND_ALLOC, 16'h0003, 16'd0);      // zero pages with pool full
      send_request(KIND_ALLOC, 16'h0003, 16'd1);
      send_request(KIND_RELEASE, 16'h1234, 16'hFFFF);
      send_request(KIND_RELEASE, 16'hFFFF, 16'd0);
      send_request(KIND_ALLOC, 16'h0004, 16'd2);
      send_request(KIND_RELEASE, 16'h0002, 16'd0);
      send_request(KIND_ALLOC, 16'h0005, 16'd6);
      send_request(KIND_ALLOC, 16'h0006, 16'd4);
      send_request(KIND_ALLOC, 16'h0007, 16'd8);
      send_request(KIND_RELEASE, 16'h0006, 16'd0);
      send_request(KIND_ALLOC, 16'h0008, 16'd9);      // spans the hole
      send_request(KIND_RELEASE, 16'h0000, 16'd0);
      send_request(KIND_ALLOC, 16'h0000, 16'hFFFE);
      send_request(KIND_RELEASE, 16'h0004, 16'd0);
      send_request(KIND_RELEASE, 16'h0005, 16'd0);
      send_request(KIND_RELEASE, 16'h0007, 16'd0);
      send_request(KIND_RELEASE, 16'h0008, 16'd0);
      send_request(KIND_ALLOC, 16'hAAAA, 16'd128);    // whole pool
      send_request(KIND_RELEASE, 16'hAAAA, 16'd0);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_page_size(sizes[p]);
         no_idle = (p == 2);
         run_random(200);
         drain();
      end
      no_idle = 1'b0;

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
